>>> rtl/lkv_pkg.sv
// lkv_pkg: shared types and constants of the lru key-value cache
// request and response structs, command codes and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // width of the key and value fields on the ports
  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [FIELD_BITS-1:0] key;
    logic [FIELD_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                  status;
    logic [FIELD_BITS-1:0] read_value;
    logic                  evicted;
    logic [FIELD_BITS-1:0] evicted_key;
  } rsp_t;

endpackage

>>> rtl/lkv_in_reg.sv
// lkv_in_reg: input register stage of the lru key-value cache
// holds one request until the store takes it; uses lkv_pkg
`timescale 1ns / 1ps

module lkv_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lkv_pkg::req_t in_req_i,
  input  logic          take_i,
  output logic          valid_o,
  output lkv_pkg::req_t req_o
);

  logic          valid_q, valid_d;
  lkv_pkg::req_t req_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

>>> rtl/lkv_store.sv
// lkv_store: entry arrays, parallel key match, recency ranks and update
// produces the response of the held request combinationally; uses lkv_pkg
`timescale 1ns / 1ps

module lkv_store #(
  parameter int unsigned ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  lkv_pkg::req_t req_i,
  output lkv_pkg::rsp_t rsp_o
);

  localparam int unsigned FB        = lkv_pkg::FIELD_BITS;
  localparam int unsigned RANK_BITS = $clog2(ENTRIES);
  localparam int unsigned CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int unsigned KW        = (KEY_BITS > FB) ? KEY_BITS : FB;
  localparam int unsigned VW        = (VALUE_BITS > FB) ? VALUE_BITS : FB;

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [RANK_BITS-1:0]  rank_q [ENTRIES];
  logic [RANK_BITS-1:0]  rank_d [ENTRIES];
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];
  logic [CNT_BITS-1:0]   count_q, count_d;

  logic [KW-1:0]         key_in_ext;
  logic [VW-1:0]         value_in_ext;
  logic [KEY_BITS-1:0]   k;
  logic [VALUE_BITS-1:0] v;
  logic [CNT_BITS-1:0]   cnt_m1;

  logic [ENTRIES-1:0]    hit_oh, lru_oh, free_oh, sel_oh, write_oh;
  logic                  any_hit, full, empty;
  logic [RANK_BITS-1:0]  hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]   lru_key;
  logic [KW-1:0]         lru_key_ext;
  logic [VW-1:0]         hit_value_ext;

  assign key_in_ext   = KW'(req_i.key);
  assign value_in_ext = VW'(req_i.value);
  assign k            = key_in_ext[KEY_BITS-1:0];
  assign v            = value_in_ext[VALUE_BITS-1:0];
  assign cnt_m1       = count_q - CNT_BITS'(1);
  assign full         = (count_q == CNT_BITS'(ENTRIES));
  assign empty        = (count_q == '0);

  // lowest clear bit of the valid vector
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh[i] = valid_q[i] && (key_q[i] == k);
      // the least recent entry carries the rank count-1
      lru_oh[i] = valid_q[i] && (rank_q[i] == cnt_m1[RANK_BITS-1:0]);
    end
  end

  assign any_hit = |hit_oh;

  // and-or selection over the one-hot vectors
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    lru_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (rank_q[i]  & {RANK_BITS{hit_oh[i]}});
      hit_value = hit_value | (value_q[i] & {VALUE_BITS{hit_oh[i]}});
      lru_key   = lru_key   | (key_q[i]   & {KEY_BITS{lru_oh[i]}});
    end
  end

  assign sel_oh        = any_hit ? hit_oh : (full ? lru_oh : free_oh);
  assign lru_key_ext   = KW'(lru_key);
  assign hit_value_ext = VW'(hit_value);

  always_comb begin
    valid_d  = valid_q;
    count_d  = count_q;
    rank_d   = rank_q;
    write_oh = '0;
    rsp_o    = '0;
    rsp_o.status = lkv_pkg::STATUS_MISS;
    unique case (req_i.cmd)
      lkv_pkg::CMD_INSERT: begin
        rsp_o.status = lkv_pkg::STATUS_OK;
        write_oh     = sel_oh;
        if (!any_hit && full) begin
          rsp_o.evicted     = 1'b1;
          rsp_o.evicted_key = lru_key_ext[FB-1:0];
        end
        if (!any_hit && !full) begin
          count_d = count_q + CNT_BITS'(1);
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (sel_oh[i]) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i] && (!any_hit || rank_q[i] < hit_rank)) begin
            // the selected entry takes rank 0; on a miss all others move down, on a hit only the more recent ones
            rank_d[i] = rank_q[i] + RANK_BITS'(1);
          end
        end
      end
      lkv_pkg::CMD_GET: begin
        if (any_hit) begin
          rsp_o.status     = lkv_pkg::STATUS_OK;
          rsp_o.read_value = hit_value_ext[FB-1:0];
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && rank_q[i] < hit_rank) begin
              rank_d[i] = rank_q[i] + RANK_BITS'(1);
            end
          end
        end
      end
      lkv_pkg::CMD_REMOVE: begin
        if (!empty) begin
          rsp_o.status      = lkv_pkg::STATUS_OK;
          rsp_o.evicted     = 1'b1;
          rsp_o.evicted_key = lru_key_ext[FB-1:0];
          valid_d           = valid_q & ~lru_oh;
          count_d           = count_q - CNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (fire_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire_i && write_oh[i]) begin
        key_q[i]   <= k;
        value_q[i] <= v;
      end
    end
  end

  // fill count tracks the valid bits
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(valid_q))
    else $error("fill count differs from number of valid entries");

  // keys stay unique, so at most one entry matches
  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_oh))
    else $error("more than one entry matches the key");

  // a non-empty store has exactly one least recent entry
  a_lru_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $onehot(lru_oh))
    else $error("recency ranks are not a permutation");

  // an insert always leaves the store non-empty
  a_insert_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && req_i.cmd == lkv_pkg::CMD_INSERT) |=> !empty)
    else $error("store empty after insert");

endmodule

>>> rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value cache with lru order
// a request is held in the input register, its response in the result register
// throughput: one request per cycle unless the output stalls, set by the
// combinational parallel key compare and rank update of all lkv_store entries
// reset: valid bits, ranks and fill count clear at once, no clearing pass
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lkv_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lkv_pkg::rsp_t out_rsp_o
);

  logic          stage_valid;
  lkv_pkg::req_t stage_req;
  logic          advance;
  lkv_pkg::rsp_t rsp;
  logic          out_valid_q, out_valid_d;
  lkv_pkg::rsp_t out_rsp_q;

  // the held request moves on whenever the result register is free
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  lkv_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  lkv_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (stage_req),
    .rsp_o  (rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> tb/tb_lru_key_value_cache.sv
// tb_lru_key_value_cache: self-checking testbench for the lru key-value cache
// mirrors the entries and their recency order to predict every response
// depends on lkv_pkg and lru_key_value_cache
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int unsigned SLOTS = lkv_pkg::DEF_ENTRIES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned POOL_KEYS = 24;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready_o;
  lkv_pkg::req_t in_req;
  logic out_valid_o;
  logic out_ready;
  lkv_pkg::rsp_t out_rsp_o;

  lru_key_value_cache dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  // mirror of the cache contents
  logic                           mirror_valid[SLOTS];
  logic [lkv_pkg::FIELD_BITS-1:0] mirror_key[SLOTS];
  logic [lkv_pkg::FIELD_BITS-1:0] mirror_value[SLOTS];
  logic [3:0]                     mirror_rank[SLOTS];

  lkv_pkg::rsp_t pending_responses[$];

  int error_count = 0;
  int request_count = 0;
  int hit_count = 0;
  int miss_count = 0;
  int evict_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[lru_key_value_cache] ERROR");
    $finish;
  end

  function automatic int find_slot(logic [lkv_pkg::FIELD_BITS-1:0] k);
    for (int i = 0; i < SLOTS; i++) begin
      if (mirror_valid[i] && mirror_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (mirror_valid[i] && (best < 0 || mirror_rank[i] > mirror_rank[best])) best = i;
    end
    return best;
  endfunction

  // entries more recent than the slot move down one place
  function automatic void make_recent(int slot);
    logic [3:0] old_rank;
    old_rank = mirror_rank[slot];
    for (int i = 0; i < SLOTS; i++) begin
      if (i != slot && mirror_valid[i] && mirror_rank[i] < old_rank) begin
        mirror_rank[i] = mirror_rank[i] + 4'd1;
      end
    end
    mirror_rank[slot] = '0;
  endfunction

  // expected response of one request; updates the mirror
  function automatic lkv_pkg::rsp_t cache_response(lkv_pkg::req_t r);
    lkv_pkg::rsp_t rsp;
    int slot;
    rsp = '0;
    rsp.status = lkv_pkg::STATUS_MISS;
    case (r.cmd)
      lkv_pkg::CMD_INSERT: begin
        slot = find_slot(r.key);
        if (slot < 0) begin
          slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!mirror_valid[i]) slot = i;
          end
          if (slot < 0) begin
            slot = oldest_slot();
            rsp.evicted = 1'b1;
            rsp.evicted_key = mirror_key[slot];
          end else begin
            mirror_valid[slot] = 1'b1;
            mirror_rank[slot] = 4'(SLOTS - 1);
          end
          mirror_key[slot] = r.key;
        end
        mirror_value[slot] = r.value;
        make_recent(slot);
        rsp.status = lkv_pkg::STATUS_OK;
      end
      lkv_pkg::CMD_GET: begin
        slot = find_slot(r.key);
        if (slot >= 0) begin
          make_recent(slot);
          rsp.read_value = mirror_value[slot];
          rsp.status = lkv_pkg::STATUS_OK;
        end
      end
      lkv_pkg::CMD_REMOVE: begin
        slot = oldest_slot();
        if (slot >= 0) begin
          mirror_valid[slot] = 1'b0;
          rsp.evicted = 1'b1;
          rsp.evicted_key = mirror_key[slot];
          rsp.status = lkv_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
    request_count++;
    if (rsp.status == lkv_pkg::STATUS_OK && r.cmd == lkv_pkg::CMD_GET) hit_count++;
    if (rsp.status == lkv_pkg::STATUS_MISS) miss_count++;
    if (rsp.evicted) evict_count++;
    return rsp;
  endfunction

  function automatic lkv_pkg::req_t make_req(logic [1:0] cmd,
                                             logic [lkv_pkg::FIELD_BITS-1:0] k,
                                             logic [lkv_pkg::FIELD_BITS-1:0] v);
    lkv_pkg::req_t r;
    r.cmd = cmd;
    r.key = k;
    r.value = v;
    return r;
  endfunction

  // returns at the accepting edge; the caller sends again or lowers valid in the same step
  task automatic send_request(input lkv_pkg::req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_responses.push_back(cache_response(r));
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random idling plus long hold-offs on request
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [lkv_pkg::FIELD_BITS-1:0] want,
                                      logic [lkv_pkg::FIELD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_responses
    lkv_pkg::rsp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready === 1'b1) begin
      if (pending_responses.size() == 0) begin
        $display("%0t unexpected response: expected none, actual %h", $time, out_rsp_o);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("status", 32'(want.status), 32'(out_rsp_o.status));
        check_field("read_value", want.read_value, out_rsp_o.read_value);
        check_field("evicted", 32'(want.evicted), 32'(out_rsp_o.evicted));
        check_field("evicted_key", want.evicted_key, out_rsp_o.evicted_key);
      end
    end
  end

  task automatic test_empty_and_unused();
    send_request(make_req(lkv_pkg::CMD_REMOVE, 32'h0, 32'h0));
    send_request(make_req(lkv_pkg::CMD_GET, 32'h1234_5678, 32'h0));
    send_request(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_for_responses();
  endtask

  task automatic test_insert_get_extremes();
    send_request(make_req(lkv_pkg::CMD_INSERT, 32'h0, 32'h0));
    send_request(make_req(lkv_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0));
    send_request(make_req(lkv_pkg::CMD_INSERT, 32'h0, 32'hA5A5_A5A5));
    send_request(make_req(lkv_pkg::CMD_GET, 32'h0, 32'hFFFF_FFFF));
    send_request(make_req(lkv_pkg::CMD_GET, 32'h1, 32'h0));
    wait_for_responses();
  endtask

  // fill the remaining slots, then a new key pushes out the oldest entry
  task automatic test_fill_and_evict();
    for (int i = 0; i < SLOTS - 2; i++) begin
      send_request(make_req(lkv_pkg::CMD_INSERT, 32'h1000_0000 + i, $urandom));
    end
    send_request(make_req(lkv_pkg::CMD_INSERT, 32'h2000_0000, $urandom));
    send_request(make_req(lkv_pkg::CMD_REMOVE, 32'h0, 32'h0));
    send_request(make_req(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0));
    wait_for_responses();
  endtask

  task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
    logic [lkv_pkg::FIELD_BITS-1:0] key_pool[POOL_KEYS];
    int sent;
    int pick;
    logic [1:0] cmd;
    logic [lkv_pkg::FIELD_BITS-1:0] k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(59) == 0) begin
        // empty the store and then some
        for (int j = 0; j <= SLOTS; j++) begin
          send_request(make_req(lkv_pkg::CMD_REMOVE, $urandom, $urandom));
        end
        sent += SLOTS + 1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) cmd = lkv_pkg::CMD_INSERT;
        else if (pick < 85) cmd = lkv_pkg::CMD_GET;
        else if (pick < 96) cmd = lkv_pkg::CMD_REMOVE;
        else cmd = CMD_UNUSED;
        k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_KEYS - 1)] : $urandom;
        send_request(make_req(cmd, k, $urandom));
        sent++;
      end
    end
    wait_for_responses();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 300;
    for (int i = 0; i < 48; i++) begin
      send_request(make_req(($urandom_range(1) != 0) ? lkv_pkg::CMD_INSERT
                                                     : lkv_pkg::CMD_GET,
                            32'h3000_0000 + $urandom_range(19), $urandom));
    end
    wait_for_responses();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_ready = 1'b0;
    foreach (mirror_valid[i]) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i] = '0;
      mirror_value[i] = '0;
      mirror_rank[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_insert_get_extremes();
    test_fill_and_evict();
    test_output_stall();
    test_random_mix(430, 33, 55);
    test_random_mix(430, 55, 33);
    test_random_mix(430, 0, 0);

    repeat (10) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $display("%0t %0d responses never arrived", $time, pending_responses.size());
      error_count++;
    end
    $display("ran %0d requests: %0d get hits, %0d misses or empty, %0d evictions",
             request_count, hit_count, miss_count, evict_count);
    $display("phases: directed corners, long output stall, three idle mixes");
    if (error_count == 0) begin
      $display("[lru_key_value_cache] OK");
    end else begin
      $display("[lru_key_value_cache] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lkv_pkg.sv
rtl/lkv_in_reg.sv
rtl/lkv_store.sv
rtl/lru_key_value_cache.sv
tb/tb_lru_key_value_cache.sv
